// ===== hdl/lru_key_value_cache_defines.svh =====
// Assertion macros shared by the cache RTL.
// Plain text macros only; no dependencies.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LKVC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lkvc check failed");

// Next-cycle implication, disabled in reset.
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkvc check failed");

`endif

// ===== hdl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// No dependencies.
package lkvc_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 64;

  localparam int FIELD_W = 64;  // key/value field width on the stream ports
  localparam int CAP_W   = 5;   // capacity register width
  localparam int OCC_W   = 5;   // occupancy field width

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    CMD_GET      = 3'd0,
    CMD_CONTAINS = 3'd1,
    CMD_TOUCH    = 3'd2,
    CMD_INSERT   = 3'd3,
    CMD_ERASE    = 3'd4,
    CMD_POP_LRU  = 3'd5,
    CMD_CLEAR    = 3'd6
  } cmd_t;

  // What a cell loads on an update edge.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PREV = 2'd1,  // take the more recent neighbor (or the front input)
    CELL_NEXT = 2'd2   // take the less recent neighbor
  } cell_op_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOOK  = 4'b0010,
    ST_PICK  = 4'b0100,
    ST_APPLY = 4'b1000
  } state_t;

endpackage

// ===== hdl/lru_key_value_cache.sv =====
// Fully associative LRU key-value cache built as a recency-ordered row of cells.
// A request passes accept, key compare in every cell, one-hot gather and row shift;
// the result beat is registered with the row shift, and no new request is taken
// until the row shift is done. A stalled result beat holds the row shift.
// Reset (rst, synchronous): empty store, capacity 16, no result pending.
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // capacity register
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_wdata,
  // request stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [127:0]       s_axis_tdata,   // [63:0] key, [127:64] value_in
  input  logic [2:0]         s_axis_tuser,   // [2:0] command
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [135:0]       m_axis_tdata    // [0] ok, [64:1] value_out,
                                             // [128:65] key_out, [133:129] occupancy
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W ? CNT_W : CAP_W) + 1;
  localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

  // Control state
  state_t             state;
  logic [CAP_W-1:0]   capacity;
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   fill_next;
  logic               out_valid;

  // Request and gathered-slot registers (payload, no reset)
  cmd_t                  cmd_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  found_r;
  logic [IDX_W-1:0]      pos_r;
  logic [KEY_BITS-1:0]   hit_key_r;
  logic [VALUE_BITS-1:0] hit_val_r;

  logic                ok_q;
  logic [FIELD_W-1:0]  value_q;
  logic [FIELD_W-1:0]  key_q;
  logic [OCC_W-1:0]    occ_q;

  // Row wiring
  logic [KEY_BITS-1:0]   cell_key [ENTRIES];
  logic [VALUE_BITS-1:0] cell_val [ENTRIES];
  logic [ENTRIES-1:0]    sel_vec;

  logic                  pk_found;
  logic [IDX_W-1:0]      pk_idx;
  logic [KEY_BITS-1:0]   pk_key;
  logic [VALUE_BITS-1:0] pk_val;

  logic                  accept;
  logic                  apply_go;
  logic [CMP_W-1:0]      cap_eff;
  logic                  need_evict;

  // Row update decode
  logic                  shift_dn;
  logic                  shift_up;
  logic [IDX_W-1:0]      lim;
  logic [KEY_BITS-1:0]   front_key;
  logic [VALUE_BITS-1:0] front_val;
  logic                  ok_d;
  logic [FIELD_W-1:0]    value_d;
  logic [FIELD_W-1:0]    key_d;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  // Hold the row shift while an earlier result beat is still waiting.
  assign apply_go      = (state == ST_APPLY) && (!out_valid || m_axis_tready);

  assign cap_eff    = (CMP_W'(capacity) > ENTRIES_C) ? ENTRIES_C : CMP_W'(capacity);
  assign need_evict = (CMP_W'(fill) + 1'b1) > cap_eff;

  // ---------------------------------------------------------------------------
  // Sequencer: accept -> compare in every cell -> gather -> shift the row.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE:  if (accept) state <= ST_LOOK;
        ST_LOOK:  state <= ST_PICK;
        ST_PICK:  state <= ST_APPLY;
        ST_APPLY: if (apply_go) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Capture the request beat; keep only the stored key/value bits.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(s_axis_tuser);
      key_r <= s_axis_tdata[KEY_BITS-1:0];
      val_r <= s_axis_tdata[64 +: VALUE_BITS];
    end
  end

  // Latch the gathered slot: the matching key, or the oldest entry for pop.
  always_ff @(posedge clk) begin
    if (state == ST_PICK) begin
      found_r   <= pk_found;
      pos_r     <= pk_idx;
      hit_key_r <= pk_key;
      hit_val_r <= pk_val;
    end
  end

  // ---------------------------------------------------------------------------
  // Row update. Cell 0 is the most recent entry and cell fill-1 the oldest;
  // cells at or above fill are empty. Moving an entry to the front shifts the
  // cells in front of it back by one; removing one pulls the tail forward.
  // ---------------------------------------------------------------------------
  always_comb begin
    shift_dn  = 1'b0;
    shift_up  = 1'b0;
    lim       = pos_r;
    front_key = key_r;
    front_val = val_r;
    fill_next = fill;
    ok_d      = 1'b0;
    value_d   = '0;
    key_d     = '0;
    unique case (cmd_r)
      CMD_GET: begin
        ok_d = found_r;
        if (found_r) value_d = FIELD_W'(hit_val_r);
      end
      CMD_CONTAINS: begin
        ok_d = found_r;
      end
      CMD_TOUCH: begin
        ok_d      = found_r;
        shift_dn  = found_r;
        front_key = hit_key_r;
        front_val = hit_val_r;
      end
      CMD_INSERT: begin
        ok_d = !found_r;
        if (found_r) begin
          // update: new value, entry moves to the front
          shift_dn = 1'b1;
        end else if (need_evict) begin
          // drop the oldest and put the new key in front; an empty store
          // with zero capacity keeps nothing
          if (fill != '0) begin
            shift_dn = 1'b1;
            lim      = IDX_W'(fill - 1'b1);
          end
        end else begin
          shift_dn  = 1'b1;
          lim       = IDX_W'(fill);
          fill_next = fill + 1'b1;
        end
      end
      CMD_ERASE: begin
        ok_d = found_r;
        if (found_r) begin
          shift_up  = 1'b1;
          fill_next = fill - 1'b1;
        end
      end
      CMD_POP_LRU: begin
        ok_d = found_r;
        if (found_r) begin
          shift_up  = 1'b1;
          fill_next = fill - 1'b1;
          value_d   = FIELD_W'(hit_val_r);
          key_d     = FIELD_W'(hit_key_r);
        end
      end
      CMD_CLEAR: begin
        fill_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (apply_go) begin
      fill <= fill_next;
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply_go) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      ok_q    <= ok_d;
      value_q <= value_d;
      key_q   <= key_d;
      occ_q   <= OCC_W'(fill_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, occ_q, key_q, value_q, ok_q};

  // ---------------------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    localparam logic [IDX_W-1:0] POS = IDX_W'(i);

    cell_op_t              op;
    logic [KEY_BITS-1:0]   p_key;
    logic [VALUE_BITS-1:0] p_val;
    logic [KEY_BITS-1:0]   n_key;
    logic [VALUE_BITS-1:0] n_val;

    always_comb begin
      op = CELL_HOLD;
      if (apply_go && shift_dn && (POS <= lim)) op = CELL_PREV;
      else if (apply_go && shift_up && (POS >= lim)) op = CELL_NEXT;
    end

    if (i == 0) begin : g_front
      assign p_key = front_key;
      assign p_val = front_val;
    end else begin : g_mid
      assign p_key = cell_key[i-1];
      assign p_val = cell_val[i-1];
    end

    if (i == ENTRIES - 1) begin : g_tail
      assign n_key = '0;
      assign n_val = '0;
    end else begin : g_body
      assign n_key = cell_key[i+1];
      assign n_val = cell_val[i+1];
    end

    lkvc_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .prev_key    (p_key),
      .prev_value  (p_val),
      .next_key    (n_key),
      .next_value  (n_val),
      .look_en     (state == ST_LOOK),
      .pick_oldest (cmd_r == CMD_POP_LRU),
      .fill        (fill),
      .req_key     (key_r),
      .key         (cell_key[i]),
      .value       (cell_val[i]),
      .sel         (sel_vec[i])
    );
  end

  lkvc_pick #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W)
  ) u_pick (
    .sel    (sel_vec),
    .keys   (cell_key),
    .values (cell_val),
    .found  (pk_found),
    .idx    (pk_idx),
    .key    (pk_key),
    .value  (pk_val)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `LKVC_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, CMP_W'(fill) <= ENTRIES_C)
  `LKVC_ASSERT_NOW(a_sel_onehot, clk, rst, state == ST_PICK, $onehot0(sel_vec))
  `LKVC_ASSERT_NEXT(a_accept_look, clk, rst, accept, state == ST_LOOK)
  `LKVC_ASSERT_NEXT(a_fill_quiet, clk, rst, !apply_go, $stable(fill))
  `LKVC_ASSERT_NEXT(a_result_out, clk, rst, apply_go, m_axis_tvalid)

endmodule

// ===== hdl/lkvc_cell.sv =====
// One slot of the recency-ordered row: key, value and a registered select flag.
// Depends on lkvc_pkg.
module lkvc_cell
  import lkvc_pkg::*;
#(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int CNT_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_op_t              op,
  input  logic [KEY_BITS-1:0]   prev_key,
  input  logic [VALUE_BITS-1:0] prev_value,
  input  logic [KEY_BITS-1:0]   next_key,
  input  logic [VALUE_BITS-1:0] next_value,
  input  logic                  look_en,
  input  logic                  pick_oldest,
  input  logic [CNT_W-1:0]      fill,
  input  logic [KEY_BITS-1:0]   req_key,
  output logic [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0] value,
  output logic                  sel
);

  localparam logic [CNT_W-1:0] POS = CNT_W'(INDEX);

  logic live;
  logic oldest;
  logic match;

  assign live   = POS < fill;
  assign oldest = (fill != '0) && (POS == fill - 1'b1);
  assign match  = live && (key == req_key);

  always_ff @(posedge clk) begin
    case (op)
      CELL_PREV: begin
        key   <= prev_key;
        value <= prev_value;
      end
      CELL_NEXT: begin
        key   <= next_key;
        value <= next_value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (look_en) begin
      sel <= pick_oldest ? oldest : match;
    end
  end

endmodule

// ===== hdl/lkvc_pick.sv =====
// Encode the one-hot select vector of the row and gather the chosen slot.
// Depends on lkvc_pkg.
module lkvc_pick
  import lkvc_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int IDX_W      = 4
) (
  input  logic [ENTRIES-1:0]    sel,
  input  logic [KEY_BITS-1:0]   keys   [ENTRIES],
  input  logic [VALUE_BITS-1:0] values [ENTRIES],
  output logic                  found,
  output logic [IDX_W-1:0]      idx,
  output logic [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0] value
);

  // At most one bit is set, so an AND-OR gather needs no priority.
  always_comb begin
    found = |sel;
    idx   = '0;
    key   = '0;
    value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel[i]) begin
        idx   = idx | IDX_W'(i);
        key   = key | keys[i];
        value = value | values[i];
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for lru_key_value_cache: random and directed request beats
// against an in-bench LRU predictor, checked field by field on the result stream.
// Depends on lkvc_pkg and the lru_key_value_cache RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lkvc_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int SLOTS      = ENTRIES_DEF;
  localparam int LONG_HOLD  = 300;         // sets the length of the one long result-side stall
  localparam int TIMEOUT_NS = 5_000_000;   // far beyond the slowest legal run
  localparam int MAX_PRINTS = 50;          // keep the log short when things go badly

  // Code seven is not in cmd_t; the block must treat it as a no-op.
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]         command;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] value_in;
  } request_t;

  typedef struct packed {
    logic               ok;
    logic [FIELD_W-1:0] value_out;
    logic [FIELD_W-1:0] key_out;
    logic [OCC_W-1:0]   occupancy;
  } reply_t;

  // ---------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CAP_W-1:0]   cfg_wdata = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [127:0]       s_axis_tdata = '0;   // [63:0] key, [127:64] value_in
  logic [2:0]         s_axis_tuser = '0;   // [2:0] command
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [135:0]       m_axis_tdata;        // [0] ok, [64:1] value_out,
                                           // [128:65] key_out, [133:129] occupancy

  lru_key_value_cache dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  request_t           requests_pending[$];   // beats not yet put on the bus
  reply_t             replies_due[$];        // predicted results, oldest first
  logic [FIELD_W-1:0] key_pool[$];           // keys that recur so lookups hit
  int                 error_count = 0;

  // Idle knobs, set between phases; zero means no bursts on that side.
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  bit hold_request  = 1'b0;                  // ask the result side for one long stall
  bit hold_served   = 1'b0;

  // Predictor copy of the cache: slot contents, liveness and recency rank.
  // Rank 0 is the most recent; live slots always hold ranks 0 .. live_count-1.
  logic [FIELD_W-1:0] slot_key[SLOTS];
  logic [FIELD_W-1:0] slot_value[SLOTS];
  bit                 slot_live[SLOTS];
  int                 slot_rank[SLOTS];
  int                 live_count   = 0;
  int                 capacity_reg = int'(CAP_RESET);

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // LRU predictor
  // ---------------------------------------------------------------------------
  function automatic int lookup_slot(logic [FIELD_W-1:0] k);
    for (int i = 0; i < SLOTS; i++)
      if (slot_live[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int oldest_slot();
    if (live_count == 0) return -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_live[i] && slot_rank[i] == live_count - 1) return i;
    return -1;
  endfunction

  // Only the entries more recent than the promoted one get older.
  function automatic void promote(int s);
    int r;
    r = slot_rank[s];
    for (int i = 0; i < SLOTS; i++)
      if (slot_live[i] && slot_rank[i] < r) slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  // Close the rank gap the removed entry leaves behind.
  function automatic void evict_slot(int s);
    int r;
    r = slot_rank[s];
    slot_live[s] = 1'b0;
    slot_rank[s] = 0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_live[i] && slot_rank[i] > r) slot_rank[i]--;
    if (live_count > 0) live_count--;
  endfunction

  // Age every live entry and place the new one in the lowest free slot.
  function automatic void add_front(logic [FIELD_W-1:0] k, logic [FIELD_W-1:0] v);
    int s;
    s = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i]) slot_rank[i]++;
      else if (s < 0) s = i;
    end
    if (s < 0) return;
    slot_key[s]   = k;
    slot_value[s] = v;
    slot_live[s]  = 1'b1;
    slot_rank[s]  = 0;
    live_count++;
  endfunction

  function automatic reply_t lru_apply(request_t r);
    reply_t rep;
    int     s;
    int     cap;
    rep = '0;
    // Anything above the slot count behaves as a full-size cache.
    cap = (capacity_reg > SLOTS) ? SLOTS : capacity_reg;
    case (r.command)
      CMD_GET: begin
        s = lookup_slot(r.key);
        if (s >= 0) begin
          rep.ok        = 1'b1;
          rep.value_out = slot_value[s];
        end
      end
      CMD_CONTAINS: rep.ok = (lookup_slot(r.key) >= 0);
      CMD_TOUCH: begin
        s = lookup_slot(r.key);
        if (s >= 0) begin
          rep.ok = 1'b1;
          promote(s);
        end
      end
      CMD_INSERT: begin
        s = lookup_slot(r.key);
        if (s >= 0) begin
          // update in place: ok stays low, entry becomes the most recent
          slot_value[s] = r.value_in;
          promote(s);
        end else begin
          rep.ok = 1'b1;
          // zero capacity on an empty store: the new key is dropped at once
          if (!(cap == 0 && live_count == 0)) begin
            // evict one least recent entry before the new one lands
            if (live_count + 1 > cap) begin
              s = oldest_slot();
              if (s >= 0) evict_slot(s);
            end
            add_front(r.key, r.value_in);
          end
        end
      end
      CMD_ERASE: begin
        s = lookup_slot(r.key);
        if (s >= 0) begin
          rep.ok = 1'b1;
          evict_slot(s);
        end
      end
      CMD_POP_LRU: begin
        s = oldest_slot();
        if (s >= 0) begin
          rep.ok        = 1'b1;
          rep.key_out   = slot_key[s];
          rep.value_out = slot_value[s];
          evict_slot(s);
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          slot_live[i] = 1'b0;
          slot_rank[i] = 0;
        end
        live_count = 0;
      end
      default: ;  // unused code: no state change
    endcase
    rep.occupancy = OCC_W'(live_count);
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: advance on acceptance, insert random idle bursts
  // ---------------------------------------------------------------------------
  int src_gap = 0;

  always @(posedge clk) begin
    request_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap       <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (src_gap > 0) begin
        src_gap       <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (requests_pending.size() != 0) begin
        req = requests_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {req.value_in, req.key};
        s_axis_tuser  <= req.command;
        // a burst of idle cycles follows this beat now and then
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
          src_gap <= $urandom_range(6, 1);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  int sink_gap  = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap      <= 0;
      hold_left     <= 0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_request && !hold_served) begin
      // block the result side long enough for the request side to back up
      hold_left     <= LONG_HOLD;
      hold_served   <= 1'b1;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap      <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
      sink_gap      <= $urandom_range(5, 0);  // stall now and load a random burst length into sink_gap
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted request, check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    request_t req;
    reply_t   got;
    reply_t   want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        req.command  = s_axis_tuser;
        req.key      = s_axis_tdata[63:0];
        req.value_in = s_axis_tdata[127:64];
        replies_due.push_back(lru_apply(req));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.ok        = m_axis_tdata[0];
        got.value_out = m_axis_tdata[64:1];
        got.key_out   = m_axis_tdata[128:65];
        got.occupancy = m_axis_tdata[133:129];
        if (replies_due.size() == 0) begin
          report_mismatch("result beat with no request outstanding");
        end else begin
          want = replies_due.pop_front();
          if (got.ok !== want.ok)
            report_mismatch($sformatf("ok got %b want %b", got.ok, want.ok));
          if (got.value_out !== want.value_out)
            report_mismatch($sformatf("value_out got %h want %h",
                                      got.value_out, want.value_out));
          if (got.key_out !== want.key_out)
            report_mismatch($sformatf("key_out got %h want %h",
                                      got.key_out, want.key_out));
          if (got.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy got %0d want %0d",
                                      got.occupancy, want.occupancy));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers; all run from the negedge so queue pushes never race
  // the driver
  // ---------------------------------------------------------------------------
  function automatic void push_req(logic [2:0] cmd, logic [FIELD_W-1:0] k,
                                   logic [FIELD_W-1:0] v);
    request_t r;
    r.command  = cmd;
    r.key      = k;
    r.value_in = v;
    requests_pending.push_back(r);
  endfunction

  function automatic logic [FIELD_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Half the pool are single-bit neighbors of earlier keys, to catch a
  // compare that ignores some key bits.
  function automatic void refresh_key_pool(int n);
    key_pool.delete();
    key_pool.push_back('0);
    key_pool.push_back('1);
    while (key_pool.size() < n) begin
      if (key_pool.size() % 2 == 0)
        key_pool.push_back(random_word());
      else
        key_pool.push_back(key_pool[$urandom_range(key_pool.size() - 1)]
                           ^ (64'd1 << $urandom_range(FIELD_W - 1)));
    end
  endfunction

  function automatic request_t random_request(int insert_pct);
    request_t r;
    int       pick;
    r.value_in = random_word();
    if ($urandom_range(99) < 85) r.key = key_pool[$urandom_range(key_pool.size() - 1)];
    else r.key = random_word();
    if ($urandom_range(99) < insert_pct) begin
      r.command = CMD_INSERT;
    end else begin
      pick = $urandom_range(99);
      if (pick < 25)      r.command = CMD_GET;
      else if (pick < 39) r.command = CMD_CONTAINS;
      else if (pick < 57) r.command = CMD_TOUCH;
      else if (pick < 76) r.command = CMD_ERASE;
      else if (pick < 95) r.command = CMD_POP_LRU;
      else if (pick < 97) r.command = CMD_CLEAR;
      else                r.command = CMD_UNUSED;
    end
    return r;
  endfunction

  // Hold until every beat is sent and every result has come back.
  task automatic wait_idle();
    while (requests_pending.size() != 0 || s_axis_tvalid || replies_due.size() != 0)
      @(negedge clk);
  endtask

  // Write only while idle; the predictor takes the new value at the same edge.
  task automatic write_capacity(int cap_value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CAP_W'(cap_value);
    @(posedge clk);
    cfg_we       <= 1'b0;
    capacity_reg = cap_value;
    @(negedge clk);
  endtask

  task automatic run_phase(int cap_value, int items, int insert_pct,
                           int src_pct, int sink_pct, bit lead_clear);
    int eff;
    wait_idle();
    write_capacity(cap_value);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    // a few more keys than fit, so inserts both hit and evict
    eff = (cap_value > SLOTS) ? SLOTS : cap_value;
    refresh_key_pool(eff + 5);
    if (lead_clear) push_req(CMD_CLEAR, random_word(), random_word());
    repeat (items) requests_pending.push_back(random_request(insert_pct));
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [FIELD_W-1:0] key_a;
    key_a = 64'hA5A5_5A5A_C3C3_3C3C;
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_rank[i] = 0;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset capacity, moderate idling on both sides.
    src_idle_pct  = 25;
    sink_idle_pct = 25;
    // every lookup-style command on an empty store misses; pop returns zeros
    push_req(CMD_GET,      '0, '1);
    push_req(CMD_CONTAINS, '1, '0);
    push_req(CMD_TOUCH,    key_a, '0);
    push_req(CMD_ERASE,    key_a, '0);
    push_req(CMD_POP_LRU,  '0, '0);
    push_req(CMD_UNUSED,   '1, '1);
    // fill with extreme keys and a pair that differ only in bit 0
    push_req(CMD_INSERT,   '0, '1);
    push_req(CMD_INSERT,   '1, '0);
    push_req(CMD_INSERT,   key_a, 64'h0123_4567_89AB_CDEF);
    push_req(CMD_INSERT,   key_a ^ 64'd1, 64'hFEDC_BA98_7654_3210);
    // reads leave recency alone
    push_req(CMD_GET,      '0, '0);
    push_req(CMD_GET,      key_a, '0);
    push_req(CMD_CONTAINS, '1, '0);
    // touch and update both move an entry to the front
    push_req(CMD_TOUCH,    '0, '0);
    push_req(CMD_INSERT,   key_a, 64'h8000_0000_0000_0001);
    push_req(CMD_GET,      '1, '0);
    push_req(CMD_ERASE,    key_a ^ 64'd1, '0);
    push_req(CMD_POP_LRU,  '0, '0);
    push_req(CMD_UNUSED,   '0, '0);
    push_req(CMD_CLEAR,    '1, '1);
    push_req(CMD_GET,      '0, '0);
    push_req(CMD_INSERT,   '1, 64'd5);
    push_req(CMD_POP_LRU,  '0, '0);
    push_req(CMD_POP_LRU,  '0, '0);

    // Random phases across capacity settings, extremes included.
    run_phase(16, 260, 50, 30, 30, 1'b0);
    run_phase(1,  180, 45, 20, 40, 1'b0);
    run_phase(0,   60, 50, 30, 10, 1'b1);   // zero capacity from an empty store
    run_phase(31, 200, 55,  0,  0, 1'b0);   // above the slot count: saturates
    // long result-side stall while requests keep coming
    hold_request = 1'b1;
    run_phase(17, 180, 50, 40, 20, 1'b0);
    run_phase(3,  200, 45, 20, 20, 1'b0);   // lowered below the current fill
    run_phase(8,  260, 50, 25, 25, 1'b0);
    run_phase(2,  150, 45, 30, 30, 1'b0);
    // closing stretch with no idling at all
    run_phase(16, 200, 50,  0,  0, 1'b0);

    wait_idle();
    repeat (20) @(negedge clk);
    if (error_count == 0)
      $display("** lru_key_value_cache: PASSED **");
    else
      $display("** lru_key_value_cache: FAILED **");
    $finish;
  end

  // Watchdog for a hung handshake or a result that never comes.
  initial begin
    #(TIMEOUT_NS);
    $display("timeout: %0d results still outstanding", replies_due.size());
    $display("** lru_key_value_cache: FAILED **");
    $finish;
  end

endmodule
